// File: src/fba_pkg.sv
// Shared types and constants of the frame bitmap allocator.
`timescale 1ns / 1ps

package fba_pkg;

    // Field widths of the request and result beats and of the frame count.
    localparam int FRAME_W = 20;
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 13;
    localparam int STAT_W  = 2;
    localparam int REQ_W   = 2;

    // Frame comparisons need one bit above the frame field.
    localparam int CMP_W = FRAME_W + 1;

    // A page is 4 KiB, so the frame is the address above bit 11.
    localparam int FRAME_SHIFT = 12;

    // Defaults of the top level parameters.
    localparam int MAX_FRAMES_DEF    = 4096;
    localparam int BITS_PER_WORD_DEF = 32;

    // Frame count after reset.
    localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_MAP   = 2'd2
    } t_req;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_UNCHANGED = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_OUTSIDE   = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_LOCATE,
        S_MODIFY,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic locate;
        logic modify;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
        logic need_scan;
        logic need_locate;
        logic scan_found;
        logic scan_empty;
        logic loc_hit;
        logic out_free;
    } t_dp_stat;

endpackage

// File: src/fba_ctrl.sv
// Controller state machine of the frame bitmap allocator.
`timescale 1ns / 1ps

module fba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  fba_pkg::t_dp_stat i_stat,
    output fba_pkg::t_cmd    o_cmd
);
    import fba_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_stat.need_scan) n_state = S_SCAN;
                else if (i_stat.need_locate) n_state = S_LOCATE;
                else n_state = S_FINISH;
            end
            S_SCAN: begin
                if (i_stat.scan_found || i_stat.scan_empty) n_state = S_FINISH;
            end
            S_LOCATE: begin
                if (i_stat.loc_hit) n_state = S_MODIFY;
            end
            S_MODIFY: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Commands and the input handshake.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            S_DECIDE: begin
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_LOCATE: begin
                o_cmd.locate = 1'b1;
            end
            S_MODIFY: begin
                o_cmd.modify = 1'b1;
            end
            S_FINISH: begin
                o_cmd.finish = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/fba_datapath.sv
// Datapath of the frame bitmap allocator: bitmap memory, scan and result register.
`timescale 1ns / 1ps

module fba_datapath #(
    parameter int MAX_FRAMES    = fba_pkg::MAX_FRAMES_DEF,
    parameter int BITS_PER_WORD = fba_pkg::BITS_PER_WORD_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fba_pkg::t_cmd                i_cmd,
    output fba_pkg::t_dp_stat            o_stat,
    input  logic                         i_cfg_we,
    input  logic [fba_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic [fba_pkg::REQ_W-1:0]    i_req_type,
    input  logic [fba_pkg::FRAME_W-1:0]  i_entry_frame,
    input  logic [fba_pkg::ADDR_W-1:0]   i_map_address,
    input  logic                         i_kernel_page,
    input  logic                         i_rw_page,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [fba_pkg::FRAME_W-1:0]  o_frame,
    output logic                         o_present,
    output logic                         o_writable,
    output logic                         o_user,
    output logic [fba_pkg::STAT_W-1:0]   o_status
);
    import fba_pkg::*;

    localparam int WORD_COUNT = (MAX_FRAMES + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(BITS_PER_WORD);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORD_COUNT - 1);
    localparam logic [CMP_W-1:0]  MAX_C     = CMP_W'(MAX_FRAMES);
    localparam logic [CMP_W-1:0]  BPW_C     = CMP_W'(BITS_PER_WORD);
    localparam logic [BITS_PER_WORD-1:0] ONE_W = BITS_PER_WORD'(1);

    // Bitmap of used frames.
    logic [BITS_PER_WORD-1:0] mem [WORD_COUNT];

    // Configuration and latched request.
    logic [CNT_W-1:0]   r_frame_count;
    logic [REQ_W-1:0]   r_req_type;
    logic [FRAME_W-1:0] r_entry;
    logic [FRAME_W-1:0] r_map_frame;
    logic               r_kern;
    logic               r_wr;

    // Word walker and registered read.
    logic [WIDX_W-1:0]        r_word_idx;
    logic [CMP_W-1:0]         r_base;
    logic [BITS_PER_WORD-1:0] r_rd_data;
    logic                     r_rd_valid;
    logic [WIDX_W-1:0]        r_rd_idx;
    logic [CMP_W-1:0]         r_rd_base;
    logic [BIT_W-1:0]         r_bit_pos;

    // Allocation outcome.
    logic               r_alloc_ok;
    logic [FRAME_W-1:0] r_alloc_frame;

    // Result register.
    logic               r_out_valid;
    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_present;
    logic               r_out_writable;
    logic               r_out_user;
    logic [STAT_W-1:0]  r_out_status;

    logic [CMP_W-1:0]         entry_c;
    logic [CMP_W-1:0]         map_c;
    logic [CMP_W-1:0]         count_c;
    logic [CMP_W-1:0]         limit;
    logic [CMP_W-1:0]         target;
    logic [CMP_W-1:0]         base_next;
    logic                     map_in_mem;
    logic                     issue;
    logic                     found;
    logic                     hit;
    logic [BIT_W-1:0]         first_free;
    logic                     mem_we;
    logic [WIDX_W-1:0]        mem_waddr;
    logic [BITS_PER_WORD-1:0] mem_wdata;
    logic                     rd_en;
    logic [FRAME_W-1:0]       res_frame;
    logic                     res_present;
    logic                     res_writable;
    logic                     res_user;
    t_status                  res_status;

    // Request classification and bounds.
    assign entry_c    = {1'b0, r_entry};
    assign map_c      = {1'b0, r_map_frame};
    assign count_c    = CMP_W'(r_frame_count);
    assign limit      = (count_c < MAX_C) ? count_c : MAX_C;
    assign map_in_mem = map_c < count_c;
    assign target     = (r_req_type == REQ_FREE) ? entry_c : map_c;
    assign base_next  = r_base + BPW_C;

    // Scan: issue a read while a whole word fits below the limit.
    assign issue = base_next <= limit;
    assign found = r_rd_valid && (r_rd_data != '1);
    assign hit   = target < base_next;

    // Lowest clear bit of the word under test.
    always_comb begin
        first_free = '0;
        for (int j = BITS_PER_WORD - 1; j >= 0; j--) begin
            if (!r_rd_data[j]) first_free = BIT_W'(j);
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat             = '0;
        o_stat.clear_done  = r_word_idx == LAST_WORD;
        o_stat.need_scan   = (r_req_type == REQ_ALLOC) && (r_entry == '0);
        o_stat.need_locate = ((r_req_type == REQ_FREE) && (r_entry != '0) && (entry_c < MAX_C))
                          || ((r_req_type == REQ_MAP) && map_in_mem && (map_c < MAX_C));
        o_stat.scan_found  = found;
        o_stat.scan_empty  = !r_rd_valid && !issue;
        o_stat.loc_hit     = hit;
        o_stat.out_free    = !r_out_valid || i_ready;
    end

    // Memory write port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_idx;
        mem_wdata = r_rd_data;
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_word_idx;
            mem_wdata = '0;
        end else if (i_cmd.scan && found) begin
            mem_we    = 1'b1;
            mem_wdata = r_rd_data | (ONE_W << first_free);
        end else if (i_cmd.modify) begin
            mem_we = 1'b1;
            if (r_req_type == REQ_MAP) begin
                mem_wdata = r_rd_data | (ONE_W << r_bit_pos);
            end else begin
                mem_wdata = r_rd_data & ~(ONE_W << r_bit_pos);
            end
        end
    end

    assign rd_en = (i_cmd.scan && issue) || (i_cmd.locate && hit);

    // Bitmap memory, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (rd_en) r_rd_data <= mem[r_word_idx];
    end

    // Frame count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
        end else if (i_cfg_we) begin
            r_frame_count <= i_cfg_wdata;
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req_type  <= i_req_type;
            r_entry     <= i_entry_frame;
            r_map_frame <= i_map_address[ADDR_W-1:FRAME_SHIFT];
            r_kern      <= i_kernel_page;
            r_wr        <= i_rw_page;
        end
    end

    // Word walker: clearing pass, scan and locate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_idx <= '0;
            r_base     <= '0;
            r_rd_valid <= 1'b0;
            r_alloc_ok <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_word_idx <= (r_word_idx == LAST_WORD) ? '0 : r_word_idx + 1'b1;
            end else if (i_cmd.load) begin
                r_word_idx <= '0;
                r_base     <= '0;
                r_rd_valid <= 1'b0;
                r_alloc_ok <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_valid <= issue;
                if (issue) begin
                    r_rd_idx   <= r_word_idx;
                    r_rd_base  <= r_base;
                    r_word_idx <= r_word_idx + 1'b1;
                    r_base     <= base_next;
                end
                if (found) begin
                    r_alloc_ok    <= 1'b1;
                    r_alloc_frame <= FRAME_W'(r_rd_base + CMP_W'(first_free));
                end
            end else if (i_cmd.locate) begin
                if (hit) begin
                    r_rd_idx  <= r_word_idx;
                    r_bit_pos <= BIT_W'(target - r_base);
                end else begin
                    r_word_idx <= r_word_idx + 1'b1;
                    r_base     <= base_next;
                end
            end
        end
    end

    // Result of the latched request.
    always_comb begin
        res_frame    = '0;
        res_present  = 1'b0;
        res_writable = 1'b0;
        res_user     = 1'b0;
        res_status   = ST_UNCHANGED;
        case (r_req_type)
            REQ_ALLOC: begin
                if (r_entry != '0) begin
                    res_frame = r_entry;
                end else if (r_alloc_ok) begin
                    res_frame    = r_alloc_frame;
                    res_present  = 1'b1;
                    res_writable = r_wr;
                    res_user     = !r_kern;
                    res_status   = ST_DONE;
                end else begin
                    res_status = ST_NO_FREE;
                end
            end
            REQ_FREE: begin
                if (r_entry == '0) res_status = ST_UNCHANGED;
                else if (entry_c >= MAX_C) res_status = ST_OUTSIDE;
                else res_status = ST_DONE;
            end
            REQ_MAP: begin
                res_frame    = r_map_frame;
                res_present  = 1'b1;
                res_writable = 1'b1;
                res_status   = (map_in_mem && (map_c >= MAX_C)) ? ST_OUTSIDE : ST_DONE;
            end
            default: begin
                res_frame = r_entry;
            end
        endcase
    end

    // Result register; a waiting beat holds until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_frame    <= res_frame;
            r_out_present  <= res_present;
            r_out_writable <= res_writable;
            r_out_user     <= res_user;
            r_out_status   <= res_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_frame    = r_out_frame;
    assign o_present  = r_out_present;
    assign o_writable = r_out_writable;
    assign o_user     = r_out_user;
    assign o_status   = r_out_status;

endmodule

// File: src/frame_bitmap_allocator.sv
// Top level of the first-fit frame bitmap allocator.
//
// Requests arrive as beats on the slave stream (i_s_*), one result leaves
// for each request on the master stream (o_m_*). The frame count register is
// written through i_cfg_we / i_cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. One request is
// handled at a time. A request is taken only in the idle state, and o_s_tready
// is low while one is in progress. Allocate scans the bitmap one word per cycle
// through the single memory read port. Free and direct map walk to the frame's
// word one word per cycle, then read, modify and write it. Requests that touch
// no bitmap word go from the decide state straight to the result.
// After reset a clearing pass writes zero to every bitmap word, one word per
// cycle; no request is taken meanwhile.
// The result sits in an output register. If the receiver stalls, the result
// holds there, and the next request is accepted and worked on, but its own
// result waits until the register is free.
`timescale 1ns / 1ps

module frame_bitmap_allocator #(
    parameter int MAX_FRAMES    = fba_pkg::MAX_FRAMES_DEF,
    parameter int BITS_PER_WORD = fba_pkg::BITS_PER_WORD_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [fba_pkg::CNT_W-1:0] i_cfg_wdata,  // frame_count
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // entry_frame[19:0], map_address[51:20], kernel_page[52], rw_page[53], zero[55:54]
    input  logic [55:0]               i_s_tdata,
    input  logic [1:0]                i_s_tuser,    // req_type[1:0]
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // frame[19:0], present[20], writable[21], user[22], zero[23]
    output logic [23:0]               o_m_tdata,
    output logic [1:0]                o_m_tuser     // status[1:0]
);
    import fba_pkg::*;

    t_cmd               cmd;
    t_dp_stat           stat;
    logic [FRAME_W-1:0] out_frame;
    logic               out_present;
    logic               out_writable;
    logic               out_user;
    logic [STAT_W-1:0]  out_status;

    // Controller.
    fba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath.
    fba_datapath #(
        .MAX_FRAMES    (MAX_FRAMES),
        .BITS_PER_WORD (BITS_PER_WORD)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_s_tuser),
        .i_entry_frame  (i_s_tdata[19:0]),
        .i_map_address  (i_s_tdata[51:20]),
        .i_kernel_page  (i_s_tdata[52]),
        .i_rw_page      (i_s_tdata[53]),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_frame        (out_frame),
        .o_present      (out_present),
        .o_writable     (out_writable),
        .o_user         (out_user),
        .o_status       (out_status)
    );

    // Result beat packing.
    assign o_m_tdata = {1'b0, out_user, out_writable, out_present, out_frame};
    assign o_m_tuser = out_status;

endmodule
